/* design/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg: shared types for the rational arithmetic unit
// Operation codes, status codes, datapath commands and the micro-program.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_NEG = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    OPC_NORM = 3'd0,
    OPC_ADD  = 3'd1,
    OPC_SUB  = 3'd2,
    OPC_MUL  = 3'd3,
    OPC_DIV  = 3'd4,
    OPC_NEG  = 3'd5,
    OPC_CMP  = 3'd6
  } opc_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_ZD  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_SETB, DP_GCD, DP_DIV, DP_MUL, DP_MCHK, DP_RED,
    DP_ADDSUB, DP_NEGA, DP_NEGB, DP_RESA, DP_SGNMUL, DP_SGNDIV, DP_CHKBZ,
    DP_SAVEP, DP_CMP, DP_JB, DP_DISP, DP_END
  } dp_op_t;

  typedef enum logic [2:0] {S_AN, S_AD, S_BN, S_BD, S_K1, S_K2, S_K3, S_K4} src_t;
  typedef enum logic [1:0] {LIM_POS, LIM_A, LIM_B, LIM_AB} lim_t;
  typedef enum logic [1:0] {TGT_A, TGT_B, TGT_R} tgt_t;

  typedef struct packed {
    dp_op_t op;
    src_t   sx;
    src_t   sy;
    src_t   dst;
    lim_t   lim;
    tgt_t   tgt;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic fail;
  } dp_stat_t;

  typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_WAIT, CS_OUT} ctl_state_t;

  typedef logic [6:0] pc_t;

  localparam pc_t PC_NORM = 7'd11;
  localparam pc_t PC_NEG  = 7'd13;
  localparam pc_t PC_SUB  = 7'd16;
  localparam pc_t PC_ADD  = 7'd17;
  localparam pc_t PC_MUL  = 7'd32;
  localparam pc_t PC_DIV  = 7'd48;
  localparam pc_t PC_CMP  = 7'd65;

  function automatic logic uses_b(opc_t o);
    return (o == OPC_ADD) || (o == OPC_SUB) || (o == OPC_MUL) || (o == OPC_DIV) ||
           (o == OPC_CMP);
  endfunction

  function automatic pc_t entry(opc_t o);
    pc_t p;
    unique case (o)
      OPC_NEG: p = PC_NEG;
      OPC_SUB: p = PC_SUB;
      OPC_ADD: p = PC_ADD;
      OPC_MUL: p = PC_MUL;
      OPC_DIV: p = PC_DIV;
      OPC_CMP: p = PC_CMP;
      default: p = PC_NORM;
    endcase
    return p;
  endfunction

  function automatic cmd_t mk(dp_op_t op, src_t sx, src_t sy, src_t dst, lim_t lim,
                              tgt_t tgt);
    cmd_t c;
    c.op  = op;
    c.sx  = sx;
    c.sy  = sy;
    c.dst = dst;
    c.lim = lim;
    c.tgt = tgt;
    return c;
  endfunction

  function automatic cmd_t c_op(dp_op_t op);
    return mk(op, S_K1, S_K1, S_K1, LIM_POS, TGT_R);
  endfunction

  function automatic cmd_t c_gcd(src_t x, src_t y);
    return mk(DP_GCD, x, y, S_K1, LIM_POS, TGT_R);
  endfunction

  // dst = x / g
  function automatic cmd_t c_div(src_t x, src_t d);
    return mk(DP_DIV, x, x, d, LIM_POS, TGT_R);
  endfunction

  function automatic cmd_t c_mul(src_t x, src_t y);
    return mk(DP_MUL, x, y, S_K1, LIM_POS, TGT_R);
  endfunction

  function automatic cmd_t c_mchk(lim_t l, src_t d);
    return mk(DP_MCHK, S_K1, S_K1, d, l, TGT_R);
  endfunction

  function automatic cmd_t c_red(tgt_t t);
    return mk(DP_RED, S_K1, S_K1, S_K1, LIM_POS, t);
  endfunction

  // Micro-program. Every item starts at 0 by reducing a (and b when used),
  // then dispatches on the operation.
  function automatic cmd_t prog(pc_t pc);
    cmd_t c;
    unique case (pc)
      7'd0:  c = c_gcd(S_K1, S_K2);
      7'd1:  c = c_div(S_K1, S_K1);
      7'd2:  c = c_div(S_K2, S_K2);
      7'd3:  c = c_red(TGT_A);
      7'd4:  c = c_op(DP_JB);
      7'd5:  c = c_op(DP_SETB);
      7'd6:  c = c_gcd(S_K1, S_K2);
      7'd7:  c = c_div(S_K1, S_K1);
      7'd8:  c = c_div(S_K2, S_K2);
      7'd9:  c = c_red(TGT_B);
      7'd10: c = c_op(DP_DISP);
      // normalize
      7'd11: c = c_op(DP_RESA);
      7'd12: c = c_op(DP_END);
      // negate
      7'd13: c = c_op(DP_NEGA);
      7'd14: c = c_op(DP_RESA);
      7'd15: c = c_op(DP_END);
      // subtract falls into add
      7'd16: c = c_op(DP_NEGB);
      7'd17: c = c_gcd(S_AD, S_BD);
      7'd18: c = c_div(S_BD, S_K1);
      7'd19: c = c_div(S_AD, S_K2);
      7'd20: c = c_mul(S_AN, S_K1);
      7'd21: c = c_mchk(LIM_A, S_K3);
      7'd22: c = c_mul(S_AD, S_K1);
      7'd23: c = c_mchk(LIM_POS, S_K1);
      7'd24: c = c_mul(S_BN, S_K2);
      7'd25: c = c_mchk(LIM_B, S_K4);
      7'd26: c = c_op(DP_ADDSUB);
      7'd27: c = c_gcd(S_K1, S_K2);
      7'd28: c = c_div(S_K1, S_K1);
      7'd29: c = c_div(S_K2, S_K2);
      7'd30: c = c_red(TGT_R);
      7'd31: c = c_op(DP_END);
      // multiply
      7'd32: c = c_gcd(S_AN, S_BD);
      7'd33: c = c_div(S_AN, S_K1);
      7'd34: c = c_div(S_BD, S_K4);
      7'd35: c = c_gcd(S_BN, S_AD);
      7'd36: c = c_div(S_BN, S_K2);
      7'd37: c = c_div(S_AD, S_K3);
      7'd38: c = c_mul(S_K1, S_K2);
      7'd39: c = c_mchk(LIM_AB, S_K1);
      7'd40: c = c_mul(S_K3, S_K4);
      7'd41: c = c_mchk(LIM_POS, S_K2);
      7'd42: c = c_op(DP_SGNMUL);
      7'd43: c = c_gcd(S_K1, S_K2);
      7'd44: c = c_div(S_K1, S_K1);
      7'd45: c = c_div(S_K2, S_K2);
      7'd46: c = c_red(TGT_R);
      7'd47: c = c_op(DP_END);
      // divide
      7'd48: c = c_op(DP_CHKBZ);
      7'd49: c = c_gcd(S_AN, S_BN);
      7'd50: c = c_div(S_AN, S_K1);
      7'd51: c = c_div(S_BN, S_K4);
      7'd52: c = c_gcd(S_AD, S_BD);
      7'd53: c = c_div(S_BD, S_K2);
      7'd54: c = c_div(S_AD, S_K3);
      7'd55: c = c_mul(S_K1, S_K2);
      7'd56: c = c_mchk(LIM_A, S_K1);
      7'd57: c = c_mul(S_K3, S_K4);
      7'd58: c = c_mchk(LIM_B, S_K2);
      7'd59: c = c_op(DP_SGNDIV);
      7'd60: c = c_gcd(S_K1, S_K2);
      7'd61: c = c_div(S_K1, S_K1);
      7'd62: c = c_div(S_K2, S_K2);
      7'd63: c = c_red(TGT_R);
      7'd64: c = c_op(DP_END);
      // compare
      7'd65: c = c_mul(S_AN, S_BD);
      7'd66: c = c_op(DP_SAVEP);
      7'd67: c = c_mul(S_BN, S_AD);
      7'd68: c = c_op(DP_CMP);
      default: c = c_op(DP_END);
    endcase
    return c;
  endfunction

endpackage

/* design/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact arithmetic on 64-bit signed fractions
// Normalize, add, subtract, multiply, divide, negate and compare.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word carries the operation and
//   two fractions a = in_a_num/in_a_den and b = in_b_num/in_b_den. A word is
//   taken on a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one word per input word with the
//   reduced result (positive denominator), a status (ok, overflow, zero
//   denominator) and, for compare, the less/equal/greater flags.
//   One word is in flight at a time; in_stall stays high from acceptance
//   until the result word has been taken.
//   Run time depends on the operation and the operand values. It is set
//   by the shared iterative units: binary gcd (one step a cycle), the
//   restoring divider for each exact division and the shift-add multiplier
//   for each product. An error status ends the sequence early.
//   Reset (rst_n low, synchronous) returns the sequencer to idle; no word
//   is pending afterwards. While out_stall is high the result word holds.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic signed [63:0] in_a_num,
  input  logic signed [63:0] in_a_den,
  input  logic signed [63:0] in_b_num,
  input  logic [62:0]        in_b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_res_num,
  output logic [62:0]        out_res_den,
  output logic [1:0]         out_status,
  output logic               out_less,
  output logic               out_equal,
  output logic               out_greater
);

  // command from the sequencer, status back from the datapath
  rau_pkg::cmd_t     cmd;
  rau_pkg::dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  // operands, gcd / divide / multiply units and result registers
  rau_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_operation),
    .in_a_num     (in_a_num),
    .in_a_den     (in_a_den),
    .in_b_num     (in_b_num),
    .in_b_den     (in_b_den),
    .out_res_num  (out_res_num),
    .out_res_den  (out_res_den),
    .out_status   (out_status),
    .out_less     (out_less),
    .out_equal    (out_equal),
    .out_greater  (out_greater)
  );

endmodule

/* design/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Handshakes both channels and steps through the micro-program.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_operation,
  output logic              out_valid,
  input  logic              out_stall,
  output rau_pkg::cmd_t     cmd,
  input  rau_pkg::dp_stat_t stat
);

  rau_pkg::ctl_state_t state_r, state_nxt;
  rau_pkg::pc_t        pc_r, pc_nxt;
  rau_pkg::opc_t       opc_r, opc_nxt;
  rau_pkg::cmd_t       cur;

  assign cur = rau_pkg::prog(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::CS_IDLE;
      pc_r    <= '0;
      opc_r   <= rau_pkg::OPC_NORM;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      opc_r   <= opc_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    opc_nxt   = opc_r;
    unique case (state_r)
      rau_pkg::CS_IDLE: begin
        if (in_valid) begin
          state_nxt = rau_pkg::CS_RUN;
          pc_nxt    = '0;
          opc_nxt   = rau_pkg::opc_t'(in_operation);
        end
      end
      rau_pkg::CS_RUN: begin
        if (stat.fail) begin
          state_nxt = rau_pkg::CS_OUT;
        end else begin
          unique case (cur.op)
            rau_pkg::DP_END: state_nxt = rau_pkg::CS_OUT;
            rau_pkg::DP_JB:  pc_nxt = rau_pkg::uses_b(opc_r) ? pc_r + 7'd1
                                                             : rau_pkg::entry(opc_r);
            rau_pkg::DP_DISP: pc_nxt = rau_pkg::entry(opc_r);
            rau_pkg::DP_GCD, rau_pkg::DP_DIV, rau_pkg::DP_MUL: begin
              state_nxt = rau_pkg::CS_WAIT;
              pc_nxt    = pc_r + 7'd1;
            end
            default: pc_nxt = pc_r + 7'd1;
          endcase
        end
      end
      rau_pkg::CS_WAIT: begin
        if (!stat.busy) state_nxt = rau_pkg::CS_RUN;
      end
      rau_pkg::CS_OUT: begin
        if (!out_stall) state_nxt = rau_pkg::CS_IDLE;
      end
      default: state_nxt = rau_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state_r != rau_pkg::CS_IDLE);
    out_valid = (state_r == rau_pkg::CS_OUT);
    cmd       = rau_pkg::c_op(rau_pkg::DP_NOP);
    unique case (state_r)
      rau_pkg::CS_IDLE: begin
        if (in_valid) cmd = rau_pkg::c_op(rau_pkg::DP_LOAD);
      end
      rau_pkg::CS_RUN: begin
        if (!stat.fail && cur.op != rau_pkg::DP_END && cur.op != rau_pkg::DP_JB &&
            cur.op != rau_pkg::DP_DISP) begin
          cmd = cur;
        end
      end
      default: cmd = rau_pkg::c_op(rau_pkg::DP_NOP);
    endcase
  end

`ifndef SYNTHESIS
  a_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> state_r == rau_pkg::CS_WAIT)
    else $error("datapath busy outside wait state");
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == rau_pkg::CS_RUN)
    else $error("accepted word did not start the program");
  a_fail_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rau_pkg::CS_RUN && stat.fail) |=> state_r == rau_pkg::CS_OUT)
    else $error("failed status did not end the program");
`endif

endmodule

/* design/rau_dp.sv */
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Operand registers, binary gcd, restoring divider, shift-add multiplier.
// ----------------------------------------------------------------------------
module rau_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::cmd_t      cmd,
  output rau_pkg::dp_stat_t  stat,
  input  logic [2:0]         in_operation,
  input  logic signed [63:0] in_a_num,
  input  logic signed [63:0] in_a_den,
  input  logic signed [63:0] in_b_num,
  input  logic [62:0]        in_b_den,
  output logic signed [63:0] out_res_num,
  output logic [62:0]        out_res_den,
  output logic [1:0]         out_status,
  output logic               out_less,
  output logic               out_equal,
  output logic               out_greater
);

  logic [63:0] an_r, ad_r, bn_r, bd_r, k1_r, k2_r, k3_r, k4_r;
  logic [63:0] an_nxt, ad_nxt, bn_nxt, bd_nxt, k1_nxt, k2_nxt, k3_nxt, k4_nxt;
  logic        aneg_r, bneg_r, rnneg_r, rdneg_r, rneg_r;
  logic        aneg_nxt, bneg_nxt, rnneg_nxt, rdneg_nxt, rneg_nxt;
  logic [63:0] rn_r, rd_r, rn_nxt, rd_nxt;
  logic [63:0] g_r, gx_r, gy_r, g_nxt, gx_nxt, gy_nxt;
  logic [5:0]  gk_r, gk_nxt, cnt_r, cnt_nxt;
  logic [63:0] dq_r, rem_r, dq_nxt, rem_nxt;
  logic [63:0] mx_r, ph_r, pl_r, mx_nxt, ph_nxt, pl_nxt;
  logic [127:0] q_r, q_nxt;
  rau_pkg::status_t status_r, status_nxt;
  rau_pkg::src_t    dst_r, dst_nxt;
  logic        iscmp_r, lt_r, eq_r, gt_r, iscmp_nxt, lt_nxt, eq_nxt, gt_nxt;
  logic        gcd_run_r, div_run_r, mul_run_r, gcd_run_nxt, div_run_nxt, mul_run_nxt;

  logic [63:0] opx, opy;
  logic [64:0] rem_sh, msum;
  logic        dge;
  logic [63:0] dq_step;
  logic        limneg, mchk_ok;
  logic        wr_en;
  rau_pkg::src_t wr_sel;
  logic [63:0] wr_val;
  logic        red_neg;
  logic [64:0] sum65;
  logic [63:0] lim;
  logic [1:0]  ra, rb;
  logic        qlt, qgt;

  function automatic logic [63:0] rd_src(rau_pkg::src_t s, logic [63:0] an, logic [63:0] ad,
                                         logic [63:0] bn, logic [63:0] bd, logic [63:0] k1,
                                         logic [63:0] k2, logic [63:0] k3, logic [63:0] k4);
    logic [63:0] v;
    unique case (s)
      rau_pkg::S_AN: v = an;
      rau_pkg::S_AD: v = ad;
      rau_pkg::S_BN: v = bn;
      rau_pkg::S_BD: v = bd;
      rau_pkg::S_K1: v = k1;
      rau_pkg::S_K2: v = k2;
      rau_pkg::S_K3: v = k3;
      default:       v = k4;
    endcase
    return v;
  endfunction

  assign opx = rd_src(cmd.sx, an_r, ad_r, bn_r, bd_r, k1_r, k2_r, k3_r, k4_r);
  assign opy = rd_src(cmd.sy, an_r, ad_r, bn_r, bd_r, k1_r, k2_r, k3_r, k4_r);

  // divider step
  assign rem_sh  = {rem_r, dq_r[63]};
  assign dge     = rem_sh >= {1'b0, g_r};
  assign dq_step = {dq_r[62:0], dge};
  // multiplier step
  assign msum    = {1'b0, ph_r} + (pl_r[0] ? {1'b0, mx_r} : 65'd0);

  always_comb begin
    unique case (cmd.lim)
      rau_pkg::LIM_POS: limneg = 1'b0;
      rau_pkg::LIM_A:   limneg = aneg_r;
      rau_pkg::LIM_B:   limneg = bneg_r;
      default:          limneg = aneg_r ^ bneg_r;
    endcase
  end
  assign mchk_ok = (ph_r == 64'd0) && (!pl_r[63] || (limneg && pl_r == rau_pkg::MAG_NEG));

  always_comb begin
    wr_en  = 1'b0;
    wr_sel = cmd.dst;
    wr_val = pl_r;
    if (div_run_r && cnt_r == 6'd0) begin
      wr_en  = 1'b1;
      wr_sel = dst_r;
      wr_val = dq_step;
    end else if (cmd.op == rau_pkg::DP_MCHK && mchk_ok) begin
      wr_en  = 1'b1;
    end
  end

  assign red_neg = (rnneg_r ^ rdneg_r) && (k1_r != 64'd0);
  assign sum65   = {1'b0, k3_r} + {1'b0, k4_r};
  assign lim     = aneg_r ? rau_pkg::MAG_NEG : rau_pkg::MAG_MAX;
  assign ra      = aneg_r ? 2'd0 : ((an_r == 64'd0) ? 2'd1 : 2'd2);
  assign rb      = bneg_r ? 2'd0 : ((bn_r == 64'd0) ? 2'd1 : 2'd2);
  assign qlt     = q_r < {ph_r, pl_r};
  assign qgt     = q_r > {ph_r, pl_r};

  always_comb begin
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    k1_nxt = k1_r; k2_nxt = k2_r; k3_nxt = k3_r; k4_nxt = k4_r;
    aneg_nxt = aneg_r; bneg_nxt = bneg_r; rnneg_nxt = rnneg_r; rdneg_nxt = rdneg_r;
    rneg_nxt = rneg_r; rn_nxt = rn_r; rd_nxt = rd_r;
    g_nxt = g_r; gx_nxt = gx_r; gy_nxt = gy_r; gk_nxt = gk_r; cnt_nxt = cnt_r;
    dq_nxt = dq_r; rem_nxt = rem_r; mx_nxt = mx_r; ph_nxt = ph_r; pl_nxt = pl_r;
    q_nxt = q_r; status_nxt = status_r; dst_nxt = dst_r;
    iscmp_nxt = iscmp_r; lt_nxt = lt_r; eq_nxt = eq_r; gt_nxt = gt_r;
    gcd_run_nxt = gcd_run_r; div_run_nxt = div_run_r; mul_run_nxt = mul_run_r;

    // binary gcd, one step a cycle
    if (gcd_run_r) begin
      priority if (gx_r == 64'd0 || gy_r == 64'd0) begin
        g_nxt       = (gx_r | gy_r) << gk_r;
        gcd_run_nxt = 1'b0;
      end else if (!gx_r[0] && !gy_r[0]) begin
        gx_nxt = gx_r >> 1;
        gy_nxt = gy_r >> 1;
        gk_nxt = gk_r + 6'd1;
      end else if (!gx_r[0]) begin
        gx_nxt = gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_nxt = gy_r >> 1;
      end else if (gx_r >= gy_r) begin
        gx_nxt = (gx_r - gy_r) >> 1;
      end else begin
        gy_nxt = (gy_r - gx_r) >> 1;
      end
    end

    if (div_run_r) begin
      rem_nxt = dge ? 64'(rem_sh - {1'b0, g_r}) : rem_sh[63:0];
      dq_nxt  = dq_step;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) div_run_nxt = 1'b0;
    end

    if (mul_run_r) begin
      ph_nxt  = msum[64:1];
      pl_nxt  = {msum[0], pl_r[63:1]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) mul_run_nxt = 1'b0;
    end

    unique case (cmd.op)
      rau_pkg::DP_LOAD: begin
        k1_nxt    = in_a_num[63] ? 64'(-in_a_num) : in_a_num;
        k2_nxt    = in_a_den[63] ? 64'(-in_a_den) : in_a_den;
        rnneg_nxt = in_a_num[63];
        rdneg_nxt = in_a_den[63];
        bn_nxt    = in_b_num[63] ? 64'(-in_b_num) : in_b_num;
        bneg_nxt  = in_b_num[63];
        bd_nxt    = {1'b0, in_b_den};
        iscmp_nxt = (rau_pkg::opc_t'(in_operation) == rau_pkg::OPC_CMP);
        if (in_a_den == 64'sd0 ||
            (rau_pkg::uses_b(rau_pkg::opc_t'(in_operation)) && in_b_den == 63'd0)) begin
          status_nxt = rau_pkg::ST_ZD;
        end else begin
          status_nxt = rau_pkg::ST_OK;
        end
      end
      rau_pkg::DP_SETB: begin
        k1_nxt    = bn_r;
        k2_nxt    = bd_r;
        rnneg_nxt = bneg_r;
        rdneg_nxt = 1'b0;
      end
      rau_pkg::DP_GCD: begin
        gx_nxt      = opx;
        gy_nxt      = opy;
        gk_nxt      = '0;
        gcd_run_nxt = 1'b1;
      end
      rau_pkg::DP_DIV: begin
        dq_nxt      = opx;
        rem_nxt     = '0;
        cnt_nxt     = 6'd63;
        dst_nxt     = cmd.dst;
        div_run_nxt = 1'b1;
      end
      rau_pkg::DP_MUL: begin
        mx_nxt      = opx;
        ph_nxt      = '0;
        pl_nxt      = opy;
        cnt_nxt     = 6'd63;
        mul_run_nxt = 1'b1;
      end
      rau_pkg::DP_MCHK: begin
        if (!mchk_ok) status_nxt = rau_pkg::ST_OVF;
      end
      rau_pkg::DP_RED: begin
        if (k2_r[63] || (k1_r[63] && !(red_neg && k1_r == rau_pkg::MAG_NEG))) begin
          status_nxt = rau_pkg::ST_OVF;
        end else begin
          unique case (cmd.tgt)
            rau_pkg::TGT_A: begin
              an_nxt = k1_r; ad_nxt = k2_r; aneg_nxt = red_neg;
            end
            rau_pkg::TGT_B: begin
              bn_nxt = k1_r; bd_nxt = k2_r; bneg_nxt = red_neg;
            end
            default: begin
              rn_nxt = k1_r; rd_nxt = k2_r; rneg_nxt = red_neg;
            end
          endcase
        end
      end
      rau_pkg::DP_ADDSUB: begin
        // p1 in k3, p2 in k4, common denominator in k1
        k2_nxt    = k1_r;
        rdneg_nxt = 1'b0;
        if (aneg_r == bneg_r) begin
          if (sum65 > {1'b0, lim}) status_nxt = rau_pkg::ST_OVF;
          k1_nxt    = sum65[63:0];
          rnneg_nxt = aneg_r;
        end else if (k3_r >= k4_r) begin
          k1_nxt    = k3_r - k4_r;
          rnneg_nxt = aneg_r;
        end else begin
          k1_nxt    = k4_r - k3_r;
          rnneg_nxt = bneg_r;
        end
      end
      rau_pkg::DP_NEGA: begin
        if (an_r[63]) status_nxt = rau_pkg::ST_OVF;
        else if (an_r != 64'd0) aneg_nxt = !aneg_r;
      end
      rau_pkg::DP_NEGB: begin
        if (bn_r[63]) status_nxt = rau_pkg::ST_OVF;
        else if (bn_r != 64'd0) bneg_nxt = !bneg_r;
      end
      rau_pkg::DP_RESA: begin
        rn_nxt = an_r; rd_nxt = ad_r; rneg_nxt = aneg_r;
      end
      rau_pkg::DP_SGNMUL: begin
        rnneg_nxt = aneg_r ^ bneg_r;
        rdneg_nxt = 1'b0;
      end
      rau_pkg::DP_SGNDIV: begin
        rnneg_nxt = aneg_r;
        rdneg_nxt = bneg_r;
      end
      rau_pkg::DP_CHKBZ: begin
        if (bn_r == 64'd0) status_nxt = rau_pkg::ST_ZD;
      end
      rau_pkg::DP_SAVEP: q_nxt = {ph_r, pl_r};
      rau_pkg::DP_CMP: begin
        // rank: negative, zero, positive; equal nonzero ranks use cross products
        if (ra != rb) begin
          lt_nxt = ra < rb; eq_nxt = 1'b0; gt_nxt = ra > rb;
        end else if (ra == 2'd1) begin
          lt_nxt = 1'b0; eq_nxt = 1'b1; gt_nxt = 1'b0;
        end else begin
          eq_nxt = !qlt && !qgt;
          lt_nxt = (ra == 2'd0) ? qgt : qlt;
          gt_nxt = (ra == 2'd0) ? qlt : qgt;
        end
      end
      default: ;
    endcase

    if (wr_en) begin
      unique case (wr_sel)
        rau_pkg::S_AN: an_nxt = wr_val;
        rau_pkg::S_AD: ad_nxt = wr_val;
        rau_pkg::S_BN: bn_nxt = wr_val;
        rau_pkg::S_BD: bd_nxt = wr_val;
        rau_pkg::S_K1: k1_nxt = wr_val;
        rau_pkg::S_K2: k2_nxt = wr_val;
        rau_pkg::S_K3: k3_nxt = wr_val;
        default:       k4_nxt = wr_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcd_run_r <= 1'b0;
      div_run_r <= 1'b0;
      mul_run_r <= 1'b0;
      status_r  <= rau_pkg::ST_OK;
    end else begin
      gcd_run_r <= gcd_run_nxt;
      div_run_r <= div_run_nxt;
      mul_run_r <= mul_run_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    k1_r <= k1_nxt; k2_r <= k2_nxt; k3_r <= k3_nxt; k4_r <= k4_nxt;
    aneg_r <= aneg_nxt; bneg_r <= bneg_nxt; rnneg_r <= rnneg_nxt; rdneg_r <= rdneg_nxt;
    rneg_r <= rneg_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
    g_r <= g_nxt; gx_r <= gx_nxt; gy_r <= gy_nxt; gk_r <= gk_nxt; cnt_r <= cnt_nxt;
    dq_r <= dq_nxt; rem_r <= rem_nxt; mx_r <= mx_nxt; ph_r <= ph_nxt; pl_r <= pl_nxt;
    q_r <= q_nxt; dst_r <= dst_nxt;
    iscmp_r <= iscmp_nxt; lt_r <= lt_nxt; eq_r <= eq_nxt; gt_r <= gt_nxt;
  end

  assign stat.busy = gcd_run_r | div_run_r | mul_run_r;
  assign stat.fail = (status_r != rau_pkg::ST_OK);

  always_comb begin
    out_status  = status_r;
    out_res_num = '0;
    out_res_den = '0;
    out_less    = 1'b0;
    out_equal   = 1'b0;
    out_greater = 1'b0;
    if (status_r == rau_pkg::ST_OK) begin
      if (iscmp_r) begin
        out_less    = lt_r;
        out_equal   = eq_r;
        out_greater = gt_r;
      end else begin
        out_res_num = rneg_r ? 64'(-rn_r) : rn_r;
        out_res_den = rd_r[62:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({gcd_run_r, div_run_r, mul_run_r}))
    else $error("more than one iterative unit running");
`endif

endmodule
